FILE: rtl/plint_pkg.sv
// Shared constants for the plane and line intersection block.
// Holds the fixed field widths, the mode codes, the register indexes and the tuser flag bits.
// Depends on nothing.
package plint_pkg;

    localparam int NORMAL_W            = 18;
    localparam int NORMAL_FRAC         = 16;
    localparam int OFFSET_W            = 32;
    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int COORD_WIDTH_DEF     = 32;
    localparam int CFG_ADDR_W          = 2;
    localparam int CFG_DATA_W          = 32;

    localparam logic [1:0] MODE_LINE    = 2'd0;
    localparam logic [1:0] MODE_NEAREST = 2'd1;
    localparam logic [1:0] MODE_REFLECT = 2'd2;
    // The remaining code has no operation and answers with all zeros.
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_Z = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET   = 2'd3;

    localparam logic signed [NORMAL_W-1:0] NORMAL_Z_RESET = 18'sd65536;

    // Bit positions in the result tuser.
    localparam int USER_HIT = 0;
    localparam int USER_OVF = 1;

endpackage

FILE: rtl/plane_line_intersect_top.sv
// Plane and line intersection, nearest point on a plane and point reflection, fixed point.
// A single pipelined module with a bit-per-stage restoring divider and an output skid stage.
// Depends on plint_pkg.
//
// Usage:
//   The plane normal (Q2.16) and the offset D (Q16.16) are written through cfg_we, cfg_addr and
//   cfg_wdata while the block is idle. Items arrive on the s_ stream: s_tuser carries the mode,
//   s_tdata the point and the direction. Each item gives one result on the m_ stream: m_tdata
//   carries the result point, m_tuser the hit and overflow flags.
//   The divider has a stage per bit of the dividend width DVW, which follows from the coordinate
//   format (32 bit Q16.16 by default), and resolves one quotient bit per stage, so its depth sets
//   the latency; one item is taken every cycle while s_tready is high.
//   Reset clears all valid bits and loads the reset values of the plane registers.
//   When the receiver stalls, the item leaving the pipeline parks in a skid register and
//   s_tready drops until the skid register is drained; nothing is lost or repeated.
module plane_line_intersect_top
    import plint_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // point_x, point_y, point_z, dir_x, dir_y, dir_z from the lowest bit up.
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // mode.
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_x, result_y, result_z from the lowest bit up.
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    // hit, overflow.
    output logic [1:0]            m_tuser
);

    localparam int CW     = COORD_WIDTH;
    localparam int F      = COORD_FRAC_BITS;
    localparam int NW     = NORMAL_W;
    localparam int VW     = (CW > NW) ? CW : NW;
    localparam int PPW    = NW + CW;
    localparam int PVW    = NW + VW;
    localparam int SUMW   = NW + VW + 2;
    localparam int DSHW   = OFFSET_W + F;
    localparam int NUMW   = ((SUMW > DSHW) ? SUMW : DSHW) + 1;
    localparam int FMAX   = (F > NORMAL_FRAC) ? F : NORMAL_FRAC;
    localparam int DVW    = NUMW + FMAX + 2;
    localparam int DENW   = SUMW;
    localparam int MW     = CW + VW;
    localparam int RW     = MW + 1;
    localparam int SW     = RW + 2;
    localparam int OUT_DW = ((3*CW+7)/8)*8;

    typedef struct packed {
        logic                 kill;
        logic                 use_dir;
        logic                 qneg;
        logic [2:0][CW-1:0]   p;
        logic [2:0][VW-1:0]   v;
    } side_t;

    // Plane registers.
    logic signed [NW-1:0]       nrm_reg [3];
    logic signed [OFFSET_W-1:0] off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nrm_reg[0] <= '0;
            nrm_reg[1] <= '0;
            nrm_reg[2] <= NORMAL_Z_RESET;
            off_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_NORMAL_X: nrm_reg[0] <= cfg_wdata[NW-1:0];
                REG_NORMAL_Y: nrm_reg[1] <= cfg_wdata[NW-1:0];
                REG_NORMAL_Z: nrm_reg[2] <= cfg_wdata[NW-1:0];
                REG_OFFSET:   off_reg    <= cfg_wdata[OFFSET_W-1:0];
                default:      off_reg    <= off_reg;
            endcase
        end
    end

    logic en;
    logic skid_vld_reg;
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // Stage A: products.
    logic                  a_vld_reg;
    logic [1:0]            a_mode_reg;
    logic [2:0][CW-1:0]    a_p_reg;
    logic [2:0][VW-1:0]    a_v_reg;
    logic signed [PPW-1:0] a_np_reg [3];
    logic signed [PVW-1:0] a_nv_reg [3];
    logic signed [CW-1:0]  in_p [3];
    logic signed [VW-1:0]  in_v [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_p[i] = s_tdata[i*CW +: CW];
            if (s_tuser == MODE_LINE) begin
                in_v[i] = VW'($signed(s_tdata[(3+i)*CW +: CW]));
            end else begin
                in_v[i] = VW'(nrm_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_mode_reg <= s_tuser;
            for (int i = 0; i < 3; i++) begin
                a_p_reg[i]  <= in_p[i];
                a_v_reg[i]  <= in_v[i];
                a_np_reg[i] <= nrm_reg[i] * in_p[i];
                a_nv_reg[i] <= nrm_reg[i] * in_v[i];
            end
        end
    end

    // Stage B: dot products, numerator and denominator.
    logic                   b_vld_reg;
    logic [1:0]             b_mode_reg;
    logic [2:0][CW-1:0]     b_p_reg;
    logic [2:0][VW-1:0]     b_v_reg;
    logic signed [DENW-1:0] b_den_reg;
    logic signed [NUMW-1:0] b_num_reg;
    logic signed [NUMW-1:0] off_ext;

    assign off_ext = NUMW'(off_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_mode_reg <= a_mode_reg;
            b_p_reg    <= a_p_reg;
            b_v_reg    <= a_v_reg;
            b_den_reg  <= a_nv_reg[0] + a_nv_reg[1] + a_nv_reg[2];
            b_num_reg  <= -a_np_reg[0] - a_np_reg[1] - a_np_reg[2] - (off_ext <<< F);
        end
    end

    // Stage C: magnitudes and the scaled dividend, loaded into divider slot 0.
    logic [NUMW-1:0] c_nmag;
    logic [DVW-1:0]  c_dvd;
    side_t           c_side;

    always_comb begin
        c_nmag = b_num_reg[NUMW-1] ? NUMW'(-b_num_reg) : NUMW'(b_num_reg);
        c_side.p       = b_p_reg;
        c_side.v       = b_v_reg;
        c_side.use_dir = (b_mode_reg == MODE_LINE);
        c_side.qneg    = b_num_reg[NUMW-1] ^ b_den_reg[DENW-1];
        c_side.kill    = (b_den_reg == '0);
        unique case (b_mode_reg)
            MODE_LINE:    c_dvd = DVW'(c_nmag) << (F + 1);
            MODE_NEAREST: c_dvd = DVW'(c_nmag) << (NORMAL_FRAC + 1);
            MODE_REFLECT: c_dvd = DVW'(c_nmag) << (NORMAL_FRAC + 2);
            default: begin
                c_dvd       = '0;
                c_side.kill = 1'b1;
            end
        endcase
    end

    // Restoring divider, one quotient bit per stage; quotient bits shift into the dividend.
    logic            dv_vld_reg  [DVW+1];
    logic [DENW-1:0] dv_rem_reg  [DVW+1];
    logic [DVW-1:0]  dv_dvd_reg  [DVW+1];
    logic [DENW-1:0] dv_den_reg  [DVW+1];
    side_t           dv_side_reg [DVW+1];
    logic [DENW-1:0] dv_rem_next [DVW];
    logic [DVW-1:0]  dv_dvd_next [DVW];

    always_comb begin
        logic [DENW:0] cat;
        logic [DENW:0] diff;
        logic          ge;
        for (int k = 0; k < DVW; k++) begin
            cat  = {dv_rem_reg[k], dv_dvd_reg[k][DVW-1]};
            diff = cat - {1'b0, dv_den_reg[k]};
            ge   = (cat >= {1'b0, dv_den_reg[k]});
            dv_rem_next[k] = ge ? diff[DENW-1:0] : cat[DENW-1:0];
            dv_dvd_next[k] = {dv_dvd_reg[k][DVW-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DVW; k++) begin
                dv_vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            dv_vld_reg[0] <= b_vld_reg;
            for (int k = 0; k < DVW; k++) begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_rem_reg[0]  <= '0;
            dv_dvd_reg[0]  <= c_dvd;
            dv_den_reg[0]  <= b_den_reg[DENW-1] ? DENW'(-b_den_reg) : DENW'(b_den_reg);
            dv_side_reg[0] <= c_side;
            for (int k = 0; k < DVW; k++) begin
                dv_rem_reg[k+1]  <= dv_rem_next[k];
                dv_dvd_reg[k+1]  <= dv_dvd_next[k];
                dv_den_reg[k+1]  <= dv_den_reg[k];
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
    end

    // Stage T: round the quotient half away from zero and saturate the parameter.
    logic [DVW:0]   q_inc;
    logic [DVW-1:0] q_rnd;
    logic           q_neg;
    logic           q_povf;
    logic           q_novf;
    logic [CW-1:0]  q_mag;

    always_comb begin
        q_inc  = {1'b0, dv_dvd_reg[DVW]} + (DVW+1)'(1);
        q_rnd  = q_inc[DVW:1];
        q_neg  = dv_side_reg[DVW].qneg && (q_rnd != '0);
        q_povf = (q_rnd[DVW-1:CW-1] != '0);
        q_novf = (q_rnd[DVW-1:CW] != '0) || (q_rnd[CW-1] && (q_rnd[CW-2:0] != '0));
        if (q_neg) begin
            q_mag = q_novf ? {1'b1, {(CW-1){1'b0}}} : q_rnd[CW-1:0];
        end else begin
            q_mag = q_povf ? {1'b0, {(CW-1){1'b1}}} : q_rnd[CW-1:0];
        end
    end

    logic          t_vld_reg;
    logic [CW-1:0] t_mag_reg;
    logic          t_neg_reg;
    logic          t_ovf_reg;
    side_t         t_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_vld_reg <= 1'b0;
        end else if (en) begin
            t_vld_reg <= dv_vld_reg[DVW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_mag_reg  <= q_mag;
            t_neg_reg  <= q_neg;
            t_ovf_reg  <= q_neg ? q_novf : q_povf;
            t_side_reg <= dv_side_reg[DVW];
        end
    end

    // Stage M: t times each direction or normal component, sign and magnitude.
    logic          m_vld_reg;
    logic [MW-1:0] m_prod_reg [3];
    logic [2:0]    m_sneg_reg;
    logic          m_ovf_reg;
    side_t         m_side_reg;
    logic [VW-1:0] v_mag [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v_mag[i] = t_side_reg.v[i][VW-1] ? VW'(-t_side_reg.v[i]) : t_side_reg.v[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (en) begin
            m_vld_reg <= t_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                m_prod_reg[i] <= MW'(t_mag_reg) * MW'(v_mag[i]);
                m_sneg_reg[i] <= t_neg_reg ^ t_side_reg.v[i][VW-1];
            end
            m_ovf_reg  <= t_ovf_reg;
            m_side_reg <= t_side_reg;
        end
    end

    // Stage R: round each product to the coordinate format and add the point.
    logic                 r_vld_reg;
    logic signed [SW-1:0] r_sum_reg [3];
    logic                 r_ovf_reg;
    logic                 r_kill_reg;
    logic signed [SW-1:0] r_sum [3];

    always_comb begin
        logic [RW-1:0]        mr;
        logic signed [SW-1:0] mrs;
        for (int i = 0; i < 3; i++) begin
            if (m_side_reg.use_dir) begin
                mr = ({1'b0, m_prod_reg[i]} + (RW'(1) << (F - 1))) >> F;
            end else begin
                mr = ({1'b0, m_prod_reg[i]} + (RW'(1) << (NORMAL_FRAC - 1))) >> NORMAL_FRAC;
            end
            mrs = $signed({2'b00, mr});
            r_sum[i] = SW'($signed(m_side_reg.p[i])) + (m_sneg_reg[i] ? -mrs : mrs);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_vld_reg <= 1'b0;
        end else if (en) begin
            r_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_sum_reg  <= r_sum;
            r_ovf_reg  <= m_ovf_reg;
            r_kill_reg <= m_side_reg.kill;
        end
    end

    // Stage L: saturate the coordinates; a zero denominator, as for a parallel line, or an unused mode gives all zeros.
    logic                  l_vld_reg;
    logic [3*CW-1:0]       l_res_reg;
    logic [1:0]            l_user_reg;
    logic [3*CW-1:0]       l_res;
    logic [1:0]            l_user;

    always_comb begin
        logic ovf;
        ovf = r_ovf_reg;
        for (int i = 0; i < 3; i++) begin
            if ((r_sum_reg[i][SW-1:CW-1] == '0) || (r_sum_reg[i][SW-1:CW-1] == '1)) begin
                l_res[i*CW +: CW] = r_sum_reg[i][CW-1:0];
            end else begin
                ovf = 1'b1;
                l_res[i*CW +: CW] = r_sum_reg[i][SW-1] ? {1'b1, {(CW-1){1'b0}}}
                                                       : {1'b0, {(CW-1){1'b1}}};
            end
        end
        l_user           = '0;
        l_user[USER_HIT] = 1'b1;
        l_user[USER_OVF] = ovf;
        if (r_kill_reg) begin
            l_res  = '0;
            l_user = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l_vld_reg <= 1'b0;
        end else if (en) begin
            l_vld_reg <= r_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l_res_reg  <= l_res;
            l_user_reg <= l_user;
        end
    end

    // Output register and skid register.
    logic              out_vld_reg;
    logic [3*CW-1:0]   out_res_reg;
    logic [1:0]        out_user_reg;
    logic [3*CW-1:0]   skid_res_reg;
    logic [1:0]        skid_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_tready) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= l_vld_reg;
            end
        end else if (l_vld_reg) begin
            // The result register is held, so the leaving item parks in the skid register.
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_tready) begin
            out_res_reg  <= skid_vld_reg ? skid_res_reg : l_res_reg;
            out_user_reg <= skid_vld_reg ? skid_user_reg : l_user_reg;
        end else if (en) begin
            skid_res_reg  <= l_res_reg;
            skid_user_reg <= l_user_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_DW'(out_res_reg);
    assign m_tuser  = out_user_reg;

endmodule

FILE: rtl/plint_check.sv
// Port-level checks for the plane and line intersection block, bound to its top level.
// Depends on plint_pkg and plane_line_intersect_top.
module plint_check
    import plint_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_tvalid,
    input logic                                   s_tready,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((3*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,
    input logic [1:0]                             m_tuser
);

    // A held result keeps its contents until the transfer.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A miss carries no point and no overflow.
    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[USER_HIT] |-> (m_tdata == '0) && !m_tuser[USER_OVF])
        else $error("miss with nonzero payload");

    // The input side only backs off while a result is waiting.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input not ready with no result pending");

    // Reset empties the result channel.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Reset leaves the input side ready.
    a_rst_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

bind plane_line_intersect_top plint_check #(.COORD_WIDTH(COORD_WIDTH)) u_plint_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: bench/tb_top.sv
// Self-checking testbench for plane_line_intersect_top: directed table, then random phases.
// Expected points come from the table or a fixed-point predictor here; depends on plint_pkg, plane_line_intersect_top.
module tb_top;
    import plint_pkg::*;

    localparam int CW        = 32;
    localparam int LIMIT     = 300000;
    localparam int HOLD_LEN  = 400;
    localparam int TAIL      = 120;
    localparam int PHASE_LEN = 117;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic            hit;
        logic            ovf;
        logic [CW-1:0]   x;
        logic [CW-1:0]   y;
        logic [CW-1:0]   z;
    } pt_result_t;

    typedef struct {
        logic [1:0]   mode;
        logic [191:0] data;
        bit           lit;
        pt_result_t   want;
    } stim_row_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;

    logic signed [17:0] plane_n [3];
    logic signed [31:0] plane_d;

    pt_result_t pending_pts[$];
    int         snd_idle = 24;
    int         rcv_idle = 79;
    int         hold_left = 0;
    int         cycles = 0;
    bit         failed = 0;

    plane_line_intersect_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    function automatic wide_t wabs(wide_t a);
        return a < 0 ? -a : a;
    endfunction

    // Clamp to the signed coordinate range and flag any clamping.
    function automatic logic [CW-1:0] clamp_coord(wide_t v, ref logic ovf);
        if (v > wide_t'(32'sh7fffffff)) begin
            ovf = 1;
            return 32'h7fffffff;
        end
        if (v < -wide_t'(64'sh80000000)) begin
            ovf = 1;
            return 32'h80000000;
        end
        return v[CW-1:0];
    endfunction

    function automatic pt_result_t plane_answer(logic [1:0] mode, logic [191:0] data);
        pt_result_t         r;
        logic signed [31:0] pc [3];
        logic signed [31:0] vc [3];
        wide_t              den, num, q, t, m;
        logic [CW-1:0]      coord [3];
        int                 fv, sh;
        logic               ovf, neg;
        r = '0;
        ovf = 0;
        for (int i = 0; i < 3; i++) begin
            pc[i] = data[32*i +: 32];
            vc[i] = (mode == MODE_LINE) ? data[96+32*i +: 32] : 32'(plane_n[i]);
        end
        if (mode != MODE_LINE && mode != MODE_NEAREST && mode != MODE_REFLECT)
            return r;
        fv = (mode == MODE_LINE) ? 16 : NORMAL_FRAC;
        sh = (mode == MODE_REFLECT) ? fv + 1 : fv;
        den = 0;
        for (int i = 0; i < 3; i++)
            den += wide_t'(plane_n[i]) * wide_t'(vc[i]);
        if (den == 0)
            return r;
        num = -(wide_t'(plane_d) <<< 16);
        for (int i = 0; i < 3; i++)
            num -= wide_t'(plane_n[i]) * wide_t'(pc[i]);
        neg = (num < 0) != (den < 0);
        q = (wabs(num) <<< (sh + 1)) / wabs(den);
        q = (q + 1) >>> 1;
        if (neg && q != 0) begin
            if (q > wide_t'(64'h80000000)) begin
                ovf = 1;
                q = wide_t'(64'h80000000);
            end
            t = -q;
        end else if (q > wide_t'(32'sh7fffffff)) begin
            ovf = 1;
            t = wide_t'(32'sh7fffffff);
        end else begin
            t = q;
        end
        for (int i = 0; i < 3; i++) begin
            m = (wabs(t) * wabs(wide_t'(vc[i])) + (wide_t'(1) <<< (fv - 1))) >>> fv;
            if ((t < 0) != (vc[i] < 0))
                m = -m;
            coord[i] = clamp_coord(wide_t'(pc[i]) + m, ovf);
        end
        r.hit = 1;
        r.ovf = ovf;
        r.x = coord[0];
        r.y = coord[1];
        r.z = coord[2];
        return r;
    endfunction

    function automatic logic [191:0] pack_item(int px, int py, int pz, int dx, int dy, int dz);
        return {dz[31:0], dy[31:0], dx[31:0], pz[31:0], py[31:0], px[31:0]};
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2: return 32'($signed($urandom_range(2097151)) - 1048576);
            3: return 32'($signed($urandom_range(536870911)) - 268435456);
            4: return 32'($signed($urandom_range(16)) - 8) <<< 16;
            default: begin
                case ($urandom_range(3))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    2: return 32'h00000000;
                    default: return 32'hffffffff;
                endcase
            end
        endcase
    endfunction

    function automatic logic [17:0] rand_normal();
        case ($urandom_range(5))
            0: return 18'sd65536;
            1: return -18'sd65536;
            2: return '0;
            3: return 18'($signed($urandom_range(65536)) - 32768);
            default: return 18'($urandom);
        endcase
    endfunction

    task automatic set_plane(logic [17:0] nx, logic [17:0] ny, logic [17:0] nz,
                             logic [31:0] d);
        logic [31:0] vals [4];
        vals = '{32'(nx), 32'(ny), 32'(nz), d};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1;
            cfg_addr  <= (i == 0) ? REG_NORMAL_X : (i == 1) ? REG_NORMAL_Y :
                         (i == 2) ? REG_NORMAL_Z : REG_OFFSET;
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 0;
        plane_n[0] = nx;
        plane_n[1] = ny;
        plane_n[2] = nz;
        plane_d    = d;
    endtask

    task automatic send_item(logic [1:0] mode, logic [191:0] data, bit lit, pt_result_t want);
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= mode;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_pts.push_back(lit ? want : plane_answer(mode, data));
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_pts.size() != 0)
            @(posedge aclk);
        repeat (TAIL) @(posedge aclk);
    endtask

    task automatic random_item();
        logic [1:0]   mode;
        logic [31:0]  d [3];
        int           r;
        r = $urandom_range(15);
        mode = (r < 6) ? MODE_LINE : (r < 10) ? MODE_NEAREST :
               (r < 14) ? MODE_REFLECT : MODE_UNUSED;
        for (int i = 0; i < 3; i++)
            d[i] = ($urandom_range(5) == 0) ? 32'd0 : rand_coord();
        send_item(mode, pack_item(rand_coord(), rand_coord(), rand_coord(), d[0], d[1], d[2]),
                  0, '0);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
            failed = 1;
        end
    endfunction

    always @(posedge aclk) begin
        pt_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pts.size() == 0) begin
                $display("%0t unexpected transfer: expected none actual %h %h",
                         $time, m_tuser, m_tdata);
                failed = 1;
            end else begin
                want = pending_pts.pop_front();
                check_field("hit", 32'(want.hit), 32'(m_tuser[USER_HIT]));
                check_field("overflow", 32'(want.ovf), 32'(m_tuser[USER_OVF]));
                check_field("result_x", want.x, m_tdata[31:0]);
                check_field("result_y", want.y, m_tdata[63:32]);
                check_field("result_z", want.z, m_tdata[95:64]);
            end
        end
    end

    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        int        sent;
        aresetn   = 0;
        cfg_we    = 0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 0;
        s_tdata   = '0;
        s_tuser   = MODE_LINE;
        plane_n   = '{18'sd0, 18'sd0, NORMAL_Z_RESET};
        plane_d   = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Reset plane is z = 0 with a unit normal along z.
        rows.push_back('{MODE_NEAREST, pack_item(5 <<< 16, 6 <<< 16, 7 <<< 16, 0, 0, 0), 1,
                         '{1'b1, 1'b0, 32'd327680, 32'd393216, 32'd0}});
        rows.push_back('{MODE_REFLECT, pack_item(1 <<< 16, 2 <<< 16, 3 <<< 16, 0, 0, 0), 1,
                         '{1'b1, 1'b0, 32'd65536, 32'd131072, -32'sd196608}});
        rows.push_back('{MODE_LINE, pack_item(0, 0, 1 <<< 16, 1 <<< 16, 1 <<< 16, -(1 <<< 16)),
                         1, '{1'b1, 1'b0, 32'd65536, 32'd65536, 32'd0}});
        // A direction lying in the plane never meets it.
        rows.push_back('{MODE_LINE, pack_item(3 <<< 16, 4, 5, 7 <<< 16, -9, 0), 1, '0});
        rows.push_back('{MODE_UNUSED, pack_item(-1, -1, -1, -1, -1, -1), 1, '0});
        rows.push_back('{MODE_REFLECT, pack_item(32'h7fffffff, 32'h80000000, 32'h80000000,
                                                 0, 0, 0), 0, '0});
        rows.push_back('{MODE_REFLECT, pack_item(0, 0, 32'h7fffffff, 0, 0, 0), 0, '0});
        rows.push_back('{MODE_LINE, pack_item(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                              32'h7fffffff, 32'h80000000, 1), 0, '0});
        rows.push_back('{MODE_LINE, pack_item(0, 0, 32'h80000000, 32'h80000000,
                                              32'h7fffffff, 32'h80000000), 0, '0});
        rows.push_back('{MODE_LINE, pack_item(1, -1, 1 <<< 16, 3, 5, -(1 <<< 15)), 0, '0});
        rows.push_back('{MODE_NEAREST, pack_item(32'h80000000, 32'h7fffffff, -1,
                                                 32'hffffffff, 32'hffffffff, 32'hffffffff),
                         0, '0});
        rows.push_back('{MODE_UNUSED, pack_item(0, 0, 0, 0, 0, 0), 1, '0});
        foreach (rows[i]) begin
            row = rows[i];
            send_item(row.mode, row.data, row.lit, row.want);
        end
        drain();

        sent = 0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: ;
                1: set_plane(18'h1ffff, 18'h1ffff, 18'h1ffff, 32'h7fffffff);
                2: set_plane(18'h20000, 18'h20000, 18'h20000, 32'h80000000);
                3: set_plane(18'd0, 18'd0, 18'd0, $urandom);
                4: set_plane(18'd0, -18'sd65536, 18'd0, 32'(-5 <<< 16));
                default: set_plane(rand_normal(), rand_normal(), rand_normal(), rand_coord());
            endcase
            for (int k = 0; k < PHASE_LEN; k++) begin
                if (sent < 317) begin
                    snd_idle = 24;
                    rcv_idle = 79;
                end else if (sent < 634) begin
                    snd_idle = 79;
                    rcv_idle = 24;
                end else begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
                if (ph == 6 && k == 5)
                    hold_left = HOLD_LEN;
                if (ph == 7 && k == 50) begin
                    s_tvalid <= 0;
                    @(posedge aclk);
                    while (pending_pts.size() != 0)
                        @(posedge aclk);
                end
                random_item();
                sent++;
            end
            drain();
        end

        if (!failed)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
